>>> rtl/rlar_pkg.sv
// Package with the types and constants shared by the run-length attribute row files.
`timescale 1ns / 1ps
`default_nettype none
package rlar_pkg;
    localparam int MAX_COLS  = 256;
    localparam int MAX_RUNS  = 64;
    localparam int ATTR_BITS = 32;
    localparam int LEN_W     = 9;
    localparam int COL_W     = 8;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int SUM_W     = 10;
    localparam int TMP_W     = 8;

    typedef enum logic [2:0] {
        F_RESET   = 3'd0,
        F_RESIZE  = 3'd1,
        F_INSERT  = 3'd2,
        F_FIND    = 3'd3,
        F_REPLACE = 3'd4,
        F_FILL    = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_USE,
        S_SP1_RD,
        S_SP1_USE,
        S_SP2_RD,
        S_SP2_USE,
        S_SP3_RD,
        S_SP3_USE,
        S_FLUSH,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]           func;
        logic [ATTR_BITS-1:0] attr_value;
        logic [ATTR_BITS-1:0] match_attr;
        logic [COL_W-1:0]     column;
        logic [LEN_W-1:0]     count_value;
        logic                 batch_end;
    } item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ATTR_BITS-1:0] found_attr;
        logic [IDX_W-1:0]     run_index;
        logic [LEN_W-1:0]     cols_remaining;
        logic [CNT_W-1:0]     run_total;
    } result_t;
endpackage
`default_nettype wire

>>> rtl/run_length_attribute_row_core.sv
// Top level of the run-length attribute row: a sequencer over the run and staging memories.
`timescale 1ns / 1ps
`default_nettype none
// One display row's attributes are held as a list of runs (attribute, length) whose
// lengths add up to the row width. A command is transferred when start is high and busy
// is low; busy then stays high until the single result has been shown on result for one
// cycle with done high. The receiver cannot stall, so the result must be taken in that
// cycle. Reset, a rejected command and a non-final insert item go straight to the
// response state. Find, resize and replace walk the run memory one run at a time, with
// a read state and a use state for each run visited. A splice (final insert item, or
// fill) makes three passes: the runs left of the start column, the staged runs (for a
// fill, the single fill run), and all existing runs again; every pass is paced by the
// single read port of the memory it walks. The new list is built in the spare half of a
// double-banked run memory and the banks swap only when it fits, so a table overflow
// leaves the row as it was. There is no clearing pass.
module run_length_attribute_row_core
    import rlar_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire item_t   item,
    output logic         busy,
    output logic         done,
    output result_t      result
);
    localparam int MW = ATTR_BITS + LEN_W;

    state_t               state_reg, state_next;
    func_t                op_reg, op_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [SUM_W-1:0]     end_reg, end_next;
    logic [LEN_W-1:0]     q_reg, q_next;
    logic [LEN_W-1:0]     cnt_reg, cnt_next;
    logic [ATTR_BITS-1:0] attr_reg, attr_next;
    logic [ATTR_BITS-1:0] match_reg, match_next;
    logic [LEN_W-1:0]     fill_len_reg, fill_len_next;
    logic                 first_reg, first_next;
    logic                 held_valid_reg, held_valid_next;
    logic [ATTR_BITS-1:0] held_attr_reg, held_attr_next;
    logic [LEN_W-1:0]     held_len_reg, held_len_next;
    logic [TMP_W-1:0]     tmp_cnt_reg, tmp_cnt_next;
    logic                 bank_reg, bank_next;
    logic                 row0_dflt_reg, row0_dflt_next;
    logic                 rd_dflt_reg;
    logic [CNT_W-1:0]     run_count_reg, run_count_next;
    logic [LEN_W-1:0]     row_width_reg, row_width_next;
    logic [CNT_W-1:0]     staged_count_reg, staged_count_next;
    logic [LEN_W-1:0]     staged_total_reg, staged_total_next;
    logic [COL_W-1:0]     batch_start_reg, batch_start_next;
    status_t              res_status_reg, res_status_next;
    logic [ATTR_BITS-1:0] res_attr_reg, res_attr_next;
    logic [IDX_W-1:0]     res_idx_reg, res_idx_next;
    logic [LEN_W-1:0]     res_rem_reg, res_rem_next;

    // Run memory: two banks of MAX_RUNS entries, the bank bit is the address MSB.
    logic [MW-1:0]        run_mem [2*MAX_RUNS];
    logic [MW-1:0]        run_rdata_reg;
    logic                 run_we;
    logic [IDX_W:0]       run_waddr;
    logic [MW-1:0]        run_wdata;
    logic [IDX_W:0]       run_raddr;

    // Staging memory for the runs of an insert batch.
    logic [MW-1:0]        stg_mem [MAX_RUNS];
    logic [MW-1:0]        stg_rdata_reg;
    logic                 stg_we;
    logic [IDX_W-1:0]     stg_waddr;
    logic [MW-1:0]        stg_wdata;

    always_ff @(posedge clk)
    begin
        if (run_we)
        begin
            run_mem[run_waddr] <= run_wdata;
        end
        run_rdata_reg <= run_mem[run_raddr];
        if (stg_we)
        begin
            stg_mem[stg_waddr] <= stg_wdata;
        end
        stg_rdata_reg <= stg_mem[j_reg[IDX_W-1:0]];
    end

    // Entry 0 of bank 0 reads as the reset run until something is written there.
    logic [ATTR_BITS-1:0] r_attr;
    logic [LEN_W-1:0]     r_len;
    assign r_attr = rd_dflt_reg ? '0 : run_rdata_reg[MW-1:LEN_W];
    assign r_len  = rd_dflt_reg ? LEN_W'(MAX_COLS) : run_rdata_reg[LEN_W-1:0];

    // Decode of the incoming command.
    func_t            in_func;
    logic             width_bad;
    logic             col_bad;
    logic [COL_W-1:0] ins_start;
    logic [LEN_W-1:0] ins_total;
    logic             ins_full;
    logic             ins_bad;
    logic [SUM_W-1:0] ins_reach;
    assign in_func   = func_t'(item.func);
    assign width_bad = (item.count_value == '0) || (item.count_value > LEN_W'(MAX_COLS));
    assign col_bad   = {1'b0, item.column} >= row_width_reg;
    assign ins_start = (staged_count_reg == '0) ? item.column : batch_start_reg;
    assign ins_total = (staged_count_reg == '0) ? '0 : staged_total_reg;
    assign ins_full  = staged_count_reg >= CNT_W'(MAX_RUNS);
    assign ins_reach = SUM_W'(ins_start) + SUM_W'(ins_total) + SUM_W'(item.count_value);
    assign ins_bad   = (item.count_value == '0) || (ins_reach > SUM_W'(row_width_reg));

    // Shared walk arithmetic.
    logic [SUM_W-1:0] acc_sum;
    logic             walk_end;
    logic             walk_hit;
    logic             sp1_end;
    logic             sp2_end;
    assign acc_sum  = acc_reg + SUM_W'(r_len);
    assign walk_end = i_reg >= run_count_reg;
    assign walk_hit = acc_sum > SUM_W'(q_reg);
    assign sp1_end  = walk_end || (acc_reg >= SUM_W'(q_reg));
    assign sp2_end  = j_reg >= n_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (in_func)
                        F_RESIZE:  state_next = width_bad ? S_RESP : S_WALK_RD;
                        F_INSERT:
                        begin
                            if (ins_full || ins_bad || !item.batch_end)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SP1_RD;
                            end
                        end
                        F_FIND:    state_next = col_bad ? S_RESP : S_WALK_RD;
                        F_REPLACE: state_next = S_WALK_RD;
                        F_FILL:    state_next = col_bad ? S_RESP : S_SP1_RD;
                        default:   state_next = S_RESP;
                    endcase
                end
            end
            S_WALK_RD:  state_next = walk_end ? S_RESP : S_WALK_USE;
            S_WALK_USE:
            begin
                if (op_reg != F_REPLACE && walk_hit)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_SP1_RD:   state_next = sp1_end ? S_SP2_RD : S_SP1_USE;
            S_SP1_USE:  state_next = S_SP1_RD;
            S_SP2_RD:   state_next = sp2_end ? S_SP3_RD : S_SP2_USE;
            S_SP2_USE:  state_next = S_SP2_RD;
            S_SP3_RD:   state_next = walk_end ? S_FLUSH : S_SP3_USE;
            S_SP3_USE:  state_next = S_SP3_RD;
            S_FLUSH:    state_next = S_RESP;
            S_RESP:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_RESP);
        result.status         = res_status_reg;
        result.found_attr     = res_attr_reg;
        result.run_index      = res_idx_reg;
        result.cols_remaining = res_rem_reg;
        result.run_total      = run_count_reg;
    end

    // Datapath and memory control.
    logic                 push_en;
    logic                 push_merge;
    logic [ATTR_BITS-1:0] push_attr;
    logic [LEN_W-1:0]     push_len;
    logic [SUM_W-1:0]     gap;
    logic [SUM_W-1:0]     from;

    always_comb
    begin
        op_next           = op_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        n_next            = n_reg;
        acc_next          = acc_reg;
        end_next          = end_reg;
        q_next            = q_reg;
        cnt_next          = cnt_reg;
        attr_next         = attr_reg;
        match_next        = match_reg;
        fill_len_next     = fill_len_reg;
        first_next        = first_reg;
        held_valid_next   = held_valid_reg;
        held_attr_next    = held_attr_reg;
        held_len_next     = held_len_reg;
        tmp_cnt_next      = tmp_cnt_reg;
        bank_next         = bank_reg;
        run_count_next    = run_count_reg;
        row_width_next    = row_width_reg;
        staged_count_next = staged_count_reg;
        staged_total_next = staged_total_reg;
        batch_start_next  = batch_start_reg;
        res_status_next   = res_status_reg;
        res_attr_next     = res_attr_reg;
        res_idx_next      = res_idx_reg;
        res_rem_next      = res_rem_reg;
        run_we            = 1'b0;
        run_waddr         = '0;
        run_wdata         = '0;
        run_raddr         = {bank_reg, i_reg[IDX_W-1:0]};
        stg_we            = 1'b0;
        stg_waddr         = staged_count_reg[IDX_W-1:0];
        stg_wdata         = {item.attr_value, item.count_value};
        push_en           = 1'b0;
        push_merge        = 1'b0;
        push_attr         = r_attr;
        push_len          = r_len;
        gap               = SUM_W'(q_reg) - acc_reg;
        from              = (acc_reg > end_reg) ? acc_reg : end_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                i_next          = '0;
                j_next          = '0;
                acc_next        = '0;
                held_valid_next = 1'b0;
                tmp_cnt_next    = '0;
                first_next      = 1'b1;
                res_status_next = ST_OK;
                res_attr_next   = '0;
                res_idx_next    = '0;
                res_rem_next    = '0;
                if (start)
                begin
                    op_next    = in_func;
                    attr_next  = item.attr_value;
                    match_next = item.match_attr;
                    cnt_next   = item.count_value;
                    unique case (in_func)
                        F_RESET:
                        begin
                            if (width_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                run_we         = 1'b1;
                                run_waddr      = {bank_reg, IDX_W'(0)};
                                run_wdata      = {item.attr_value, item.count_value};
                                run_count_next = CNT_W'(1);
                                row_width_next = item.count_value;
                            end
                        end
                        F_RESIZE:
                        begin
                            if (width_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                q_next = ((item.count_value < row_width_reg) ?
                                          item.count_value : row_width_reg) - LEN_W'(1);
                            end
                        end
                        F_INSERT:
                        begin
                            if (staged_count_reg == '0)
                            begin
                                batch_start_next = item.column;
                            end
                            if (ins_full)
                            begin
                                res_status_next   = ST_FULL;
                                staged_count_next = '0;
                                staged_total_next = '0;
                            end
                            else if (ins_bad)
                            begin
                                res_status_next   = ST_RANGE;
                                staged_count_next = '0;
                                staged_total_next = '0;
                            end
                            else if (item.batch_end)
                            begin
                                stg_we            = 1'b1;
                                q_next            = LEN_W'(ins_start);
                                end_next          = ins_reach;
                                n_next            = staged_count_reg + CNT_W'(1);
                                staged_count_next = '0;
                                staged_total_next = '0;
                            end
                            else
                            begin
                                stg_we            = 1'b1;
                                staged_count_next = staged_count_reg + CNT_W'(1);
                                staged_total_next = LEN_W'(SUM_W'(ins_total) +
                                                           SUM_W'(item.count_value));
                            end
                        end
                        F_FIND:
                        begin
                            if (col_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            q_next = LEN_W'(item.column);
                        end
                        F_REPLACE:
                        begin
                        end
                        F_FILL:
                        begin
                            if (col_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            q_next        = LEN_W'(item.column);
                            end_next      = SUM_W'(row_width_reg);
                            fill_len_next = row_width_reg - LEN_W'(item.column);
                            n_next        = CNT_W'(1);
                        end
                        default: res_status_next = ST_RANGE;
                    endcase
                end
            end
            S_WALK_RD:
            begin
                if (walk_end && op_reg == F_FIND)
                begin
                    // Walk ran off the end: report the last run.
                    res_idx_next  = IDX_W'(run_count_reg - CNT_W'(1));
                    res_rem_next  = LEN_W'(1);
                    res_attr_next = r_attr;
                end
            end
            S_WALK_USE:
            begin
                i_next   = i_reg + CNT_W'(1);
                acc_next = acc_sum;
                unique case (op_reg)
                    F_REPLACE:
                    begin
                        if (r_attr == match_reg)
                        begin
                            run_we    = 1'b1;
                            run_waddr = {bank_reg, i_reg[IDX_W-1:0]};
                            run_wdata = {attr_reg, r_len};
                        end
                    end
                    F_RESIZE:
                    begin
                        if (walk_hit)
                        begin
                            run_we         = 1'b1;
                            run_waddr      = {bank_reg, i_reg[IDX_W-1:0]};
                            run_wdata      = {r_attr, LEN_W'(SUM_W'(r_len) +
                                              SUM_W'(cnt_reg) - acc_sum)};
                            run_count_next = i_reg + CNT_W'(1);
                            row_width_next = cnt_reg;
                        end
                    end
                    default:
                    begin
                        if (walk_hit)
                        begin
                            res_idx_next  = i_reg[IDX_W-1:0];
                            res_rem_next  = LEN_W'(acc_sum - SUM_W'(q_reg));
                            res_attr_next = r_attr;
                        end
                    end
                endcase
            end
            S_SP1_RD:
            begin
                if (sp1_end)
                begin
                    j_next = '0;
                end
            end
            S_SP1_USE:
            begin
                push_en  = 1'b1;
                push_len = (SUM_W'(r_len) < gap) ? r_len : LEN_W'(gap);
                i_next   = i_reg + CNT_W'(1);
                acc_next = acc_sum;
            end
            S_SP2_RD:
            begin
                if (sp2_end)
                begin
                    i_next     = '0;
                    acc_next   = '0;
                    first_next = 1'b1;
                end
            end
            S_SP2_USE:
            begin
                push_en    = 1'b1;
                push_merge = (j_reg == '0);
                if (op_reg == F_FILL)
                begin
                    push_attr = attr_reg;
                    push_len  = fill_len_reg;
                end
                else
                begin
                    push_attr = stg_rdata_reg[MW-1:LEN_W];
                    push_len  = stg_rdata_reg[LEN_W-1:0];
                end
                j_next = j_reg + CNT_W'(1);
            end
            S_SP3_USE:
            begin
                if (acc_sum > end_reg)
                begin
                    push_en    = 1'b1;
                    push_merge = first_reg;
                    push_len   = LEN_W'(acc_sum - from);
                    first_next = 1'b0;
                end
                i_next   = i_reg + CNT_W'(1);
                acc_next = acc_sum;
            end
            S_FLUSH:
            begin
                if (held_valid_reg && tmp_cnt_reg <= TMP_W'(MAX_RUNS))
                begin
                    run_we    = 1'b1;
                    run_waddr = {~bank_reg, IDX_W'(tmp_cnt_reg - TMP_W'(1))};
                    run_wdata = {held_attr_reg, held_len_reg};
                end
                if (tmp_cnt_reg > TMP_W'(MAX_RUNS))
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    bank_next      = ~bank_reg;
                    run_count_next = CNT_W'(tmp_cnt_reg);
                end
            end
            default:
            begin
            end
        endcase

        // Append one run to the list being built, merging with the last one when asked and the attributes match.
        if (push_en)
        begin
            if (push_merge && held_valid_reg && held_attr_reg == push_attr)
            begin
                held_len_next = LEN_W'(SUM_W'(held_len_reg) + SUM_W'(push_len));
            end
            else
            begin
                if (held_valid_reg && tmp_cnt_reg <= TMP_W'(MAX_RUNS))
                begin
                    run_we    = 1'b1;
                    run_waddr = {~bank_reg, IDX_W'(tmp_cnt_reg - TMP_W'(1))};
                    run_wdata = {held_attr_reg, held_len_reg};
                end
                held_valid_next = 1'b1;
                held_attr_next  = push_attr;
                held_len_next   = push_len;
                tmp_cnt_next    = tmp_cnt_reg + TMP_W'(1);
            end
        end
    end

    assign row0_dflt_next = row0_dflt_reg && !(run_we && run_waddr == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            bank_reg         <= 1'b0;
            row0_dflt_reg    <= 1'b1;
            rd_dflt_reg      <= 1'b0;
            run_count_reg    <= CNT_W'(1);
            row_width_reg    <= LEN_W'(MAX_COLS);
            staged_count_reg <= '0;
            staged_total_reg <= '0;
            batch_start_reg  <= '0;
            held_valid_reg   <= 1'b0;
            tmp_cnt_reg      <= '0;
            res_status_reg   <= ST_OK;
        end
        else
        begin
            state_reg        <= state_next;
            bank_reg         <= bank_next;
            row0_dflt_reg    <= row0_dflt_next;
            rd_dflt_reg      <= row0_dflt_reg && (run_raddr == '0);
            run_count_reg    <= run_count_next;
            row_width_reg    <= row_width_next;
            staged_count_reg <= staged_count_next;
            staged_total_reg <= staged_total_next;
            batch_start_reg  <= batch_start_next;
            held_valid_reg   <= held_valid_next;
            tmp_cnt_reg      <= tmp_cnt_next;
            res_status_reg   <= res_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        n_reg         <= n_next;
        acc_reg       <= acc_next;
        end_reg       <= end_next;
        q_reg         <= q_next;
        cnt_reg       <= cnt_next;
        attr_reg      <= attr_next;
        match_reg     <= match_next;
        fill_len_reg  <= fill_len_next;
        first_reg     <= first_next;
        held_attr_reg <= held_attr_next;
        held_len_reg  <= held_len_next;
        res_attr_reg  <= res_attr_next;
        res_idx_reg   <= res_idx_next;
        res_rem_reg   <= res_rem_next;
    end
endmodule
`default_nettype wire

>>> rtl/rlar_checker.sv
// Port-level checker for the run-length attribute row, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rlar_checker
    import rlar_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);
    // An accepted command always occupies the block in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // A result is only shown while a command is in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a command");

    // Each command gives one result, so strobes never come back to back.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // The row always holds at least one and at most the table size of runs.
    a_run_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.run_total != '0) && (result.run_total <= CNT_W'(MAX_RUNS)))
        else $error("run total out of range");
endmodule

bind run_length_attribute_row_core rlar_checker u_rlar_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
